// ----- hdl/nups_pkg.sv -----
`default_nettype none

package nups_pkg;

  // table geometry
  localparam int PATHS = 1024;
  localparam int AW    = (PATHS > 1) ? $clog2(PATHS) : 1;   // entry address
  localparam int CW    = $clog2(PATHS + 1);                 // scan counter, holds PATHS

  localparam int COORD_W = 24;
  localparam int IDX_W   = 10;
  localparam int CFG_W   = 11;
  localparam int SQ_W    = 2 * COORD_W;
  localparam int DIST_W  = SQ_W + 1;
  localparam int PT_W    = 4 * COORD_W;

  localparam logic OP_LOAD  = 1'b0;
  localparam logic OP_QUERY = 1'b1;

  localparam logic [1:0] ST_LOADED = 2'd0;
  localparam logic [1:0] ST_FOUND  = 2'd1;
  localparam logic [1:0] ST_NONE   = 2'd2;

  typedef enum logic [2:0] {
    S_CLEAR,
    S_IDLE,
    S_LOAD,
    S_SCAN,
    S_DRAIN,
    S_FINISH
  } state_t;

  // controller -> datapath
  typedef struct packed {
    logic clear_step;
    logic capture;
    logic load;
    logic scan;
    logic drain;
    logic finish;
  } dp_cmd_t;

  // datapath -> controller
  typedef struct packed {
    logic clear_last;
    logic scan_end;
    logic pipe_idle;
  } dp_status_t;

endpackage

`default_nettype wire

// ----- hdl/nups_ctrl.sv -----
`default_nettype none

module nups_ctrl
  import nups_pkg::*;
(
  input  wire logic       clk,
  input  wire logic       rst_n,
  input  wire logic       start,
  input  wire logic       in_opcode,
  input  wire dp_status_t status,
  output dp_cmd_t         cmd,
  output logic            busy
);

  state_t state_r, state_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_CLEAR;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_comb begin
    state_nxt = state_r;
    case (state_r)
      S_CLEAR: begin
        if (status.clear_last) state_nxt = S_IDLE;
      end
      S_IDLE: begin
        if (start) state_nxt = (in_opcode == OP_QUERY) ? S_SCAN : S_LOAD;
      end
      S_LOAD: begin
        state_nxt = S_IDLE;
      end
      S_SCAN: begin
        if (status.scan_end) state_nxt = S_DRAIN;
      end
      S_DRAIN: begin
        if (status.pipe_idle) state_nxt = S_FINISH;
      end
      S_FINISH: begin
        state_nxt = S_IDLE;
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_comb begin
    cmd  = '0;
    busy = 1'b1;
    case (state_r)
      S_CLEAR: begin
        cmd.clear_step = 1'b1;
      end
      S_IDLE: begin
        busy        = 1'b0;
        cmd.capture = start;
      end
      S_LOAD: begin
        cmd.load = 1'b1;
      end
      S_SCAN: begin
        cmd.scan = 1'b1;
      end
      S_DRAIN: begin
        cmd.drain = 1'b1;
      end
      S_FINISH: begin
        cmd.finish = 1'b1;
      end
      default: begin
        busy = 1'b1;
      end
    endcase
  end

endmodule

`default_nettype wire

// ----- hdl/nups_dpath.sv -----
`default_nettype none

module nups_dpath
  import nups_pkg::*;
(
  input  wire logic                      clk,
  input  wire logic                      rst_n,
  input  wire dp_cmd_t                   cmd,
  output dp_status_t                     status,
  input  wire logic                      cfg_wr_en,
  input  wire logic [CFG_W-1:0]          cfg_wr_data,
  input  wire logic [IDX_W-1:0]          in_entry_index,
  input  wire logic signed [COORD_W-1:0] in_start_x,
  input  wire logic signed [COORD_W-1:0] in_start_y,
  input  wire logic signed [COORD_W-1:0] in_end_x,
  input  wire logic signed [COORD_W-1:0] in_end_y,
  input  wire logic signed [COORD_W-1:0] in_query_x,
  input  wire logic signed [COORD_W-1:0] in_query_y,
  output logic                           out_strobe,
  output logic [1:0]                     out_status,
  output logic [IDX_W-1:0]               out_path_index,
  output logic                           out_reverse,
  output logic [DIST_W-1:0]              out_distance_sq
);

  function automatic logic [COORD_W-1:0] abs_diff(input logic [COORD_W-1:0] a,
                                                  input logic [COORD_W-1:0] b);
    logic signed [COORD_W:0] d;
    d = $signed({a[COORD_W-1], a}) - $signed({b[COORD_W-1], b});
    return d[COORD_W] ? COORD_W'(-d) : d[COORD_W-1:0];
  endfunction

  // point table {sx, sy, ex, ey} and pending marks
  logic [PT_W-1:0] pt_mem   [PATHS];
  logic            pend_mem [PATHS];

  logic [CFG_W-1:0]   paths_in_use_r;
  logic [CW-1:0]      cnt_r, lim_r;
  logic [AW-1:0]      ld_idx_r;
  logic               ld_ok_r;
  logic [PT_W-1:0]    ld_pt_r;
  logic [COORD_W-1:0] qx_r, qy_r;

  logic               issue;
  logic               pend_we, pend_wd;
  logic [AW-1:0]      pend_addr;

  // scan pipeline
  logic               v1_r, v2_r, v3_r, v4_r, v5_r;
  logic [AW-1:0]      idx1_r, idx2_r, idx3_r, idx4_r, idx5_r;
  logic [PT_W-1:0]    pt_rd_r;
  logic               pend_rd_r;
  logic [COORD_W-1:0] dsx_r, dsy_r, dex_r, dey_r;
  logic [SQ_W-1:0]    qsx_r, qsy_r, qex_r, qey_r;
  logic [DIST_W-1:0]  ds_r, de_r, d5_r;
  logic               rv5_r;

  logic               found_r;
  logic [AW-1:0]      best_idx_r;
  logic [DIST_W-1:0]  best_d_r;
  logic               best_rev_r;

  logic               out_strobe_r;
  logic [1:0]         out_status_r;
  logic [IDX_W-1:0]   out_path_index_r;
  logic               out_reverse_r;
  logic [DIST_W-1:0]  out_distance_sq_r;

  assign issue = cmd.scan && (cnt_r < lim_r);

  assign status.clear_last = (32'(cnt_r) == PATHS - 1);
  assign status.scan_end   = (cnt_r >= lim_r);
  assign status.pipe_idle  = !(v1_r || v2_r || v3_r || v4_r || v5_r);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      paths_in_use_r <= '0;
    end else if (cfg_wr_en) begin
      paths_in_use_r <= cfg_wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r <= '0;
    end else if (cmd.capture) begin
      cnt_r <= '0;
    end else if (cmd.clear_step || issue) begin
      cnt_r <= cnt_r + CW'(1);
    end
  end

  // captured beat
  always_ff @(posedge clk) begin
    if (cmd.capture) begin
      ld_idx_r <= AW'(in_entry_index);
      ld_ok_r  <= (32'(in_entry_index) < PATHS);
      ld_pt_r  <= {in_start_x, in_start_y, in_end_x, in_end_y};
      qx_r     <= in_query_x;
      qy_r     <= in_query_y;
      lim_r    <= (32'(paths_in_use_r) > PATHS) ? CW'(PATHS) : CW'(paths_in_use_r);
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load && ld_ok_r) begin
      pt_mem[ld_idx_r] <= ld_pt_r;
    end
    pt_rd_r <= pt_mem[cnt_r[AW-1:0]];
  end

  always_comb begin
    pend_we   = 1'b0;
    pend_wd   = 1'b0;
    pend_addr = cnt_r[AW-1:0];
    if (cmd.clear_step) begin
      pend_we = 1'b1;
    end else if (cmd.load) begin
      pend_we   = ld_ok_r;
      pend_wd   = 1'b1;
      pend_addr = ld_idx_r;
    end else if (cmd.finish) begin
      pend_we   = found_r;
      pend_addr = best_idx_r;
    end
  end

  always_ff @(posedge clk) begin
    if (pend_we) begin
      pend_mem[pend_addr] <= pend_wd;
    end
    pend_rd_r <= pend_mem[cnt_r[AW-1:0]];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r <= 1'b0;
      v2_r <= 1'b0;
      v3_r <= 1'b0;
      v4_r <= 1'b0;
      v5_r <= 1'b0;
    end else begin
      v1_r <= issue;
      v2_r <= v1_r && pend_rd_r;   // skip entries already taken
      v3_r <= v2_r;
      v4_r <= v3_r;
      v5_r <= v4_r;
    end
  end

  always_ff @(posedge clk) begin
    idx1_r <= cnt_r[AW-1:0];
    idx2_r <= idx1_r;
    idx3_r <= idx2_r;
    idx4_r <= idx3_r;
    idx5_r <= idx4_r;

    dsx_r <= abs_diff(qx_r, pt_rd_r[4*COORD_W-1:3*COORD_W]);
    dsy_r <= abs_diff(qy_r, pt_rd_r[3*COORD_W-1:2*COORD_W]);
    dex_r <= abs_diff(qx_r, pt_rd_r[2*COORD_W-1:COORD_W]);
    dey_r <= abs_diff(qy_r, pt_rd_r[COORD_W-1:0]);

    qsx_r <= dsx_r * dsx_r;
    qsy_r <= dsy_r * dsy_r;
    qex_r <= dex_r * dex_r;
    qey_r <= dey_r * dey_r;

    ds_r <= DIST_W'(qsx_r) + DIST_W'(qsy_r);
    de_r <= DIST_W'(qex_r) + DIST_W'(qey_r);

    // end point only when strictly nearer
    rv5_r <= (de_r < ds_r);
    d5_r  <= (de_r < ds_r) ? de_r : ds_r;
  end

  // running best; strict compare keeps the lowest index on a tie
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      found_r <= 1'b0;
    end else if (cmd.capture) begin
      found_r <= 1'b0;
    end else if (v5_r) begin
      found_r <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (v5_r && (!found_r || d5_r < best_d_r)) begin
      best_idx_r <= idx5_r;
      best_d_r   <= d5_r;
      best_rev_r <= rv5_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_strobe_r <= 1'b0;
    end else begin
      out_strobe_r <= cmd.load || cmd.finish;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.finish && found_r) begin
      out_status_r      <= ST_FOUND;
      out_path_index_r  <= IDX_W'(best_idx_r);
      out_reverse_r     <= best_rev_r;
      out_distance_sq_r <= best_d_r;
    end else if (cmd.load || cmd.finish) begin
      out_status_r      <= cmd.load ? ST_LOADED : ST_NONE;
      out_path_index_r  <= '0;
      out_reverse_r     <= 1'b0;
      out_distance_sq_r <= '0;
    end
  end

  assign out_strobe      = out_strobe_r;
  assign out_status      = out_status_r;
  assign out_path_index  = out_path_index_r;
  assign out_reverse     = out_reverse_r;
  assign out_distance_sq = out_distance_sq_r;

  // results never come in adjacent cycles
  a_strobe_gap: assert property (@(posedge clk) disable iff (!rst_n)
    out_strobe_r |=> !out_strobe_r)
    else $error("result beats back to back");

  // chosen entry lies within the scanned range
  a_index_range: assert property (@(posedge clk) disable iff (!rst_n)
    (out_strobe_r && out_status_r == ST_FOUND) |-> (32'(out_path_index_r) < 32'(lim_r)))
    else $error("chosen path outside scan range");

  // scan pipeline only busy while scanning or draining
  a_pipe_owner: assert property (@(posedge clk) disable iff (!rst_n)
    (v1_r || v2_r || v3_r || v4_r || v5_r) |-> (cmd.scan || cmd.drain))
    else $error("scan pipeline active outside a query");

  // a found result follows a scan that saw a pending entry
  a_found_src: assert property (@(posedge clk) disable iff (!rst_n)
    (out_strobe_r && out_status_r == ST_FOUND) |-> $past(found_r && cmd.finish))
    else $error("found result without a candidate");

endmodule

`default_nettype wire

// ----- hdl/nearest_unused_path_selector.sv -----
// Channel   Ports                                     Handshake
// config    cfg_wr_en, cfg_wr_data[10:0]              written when cfg_wr_en high
// input     in_opcode, in_entry_index, in_start_*,    taken when start && !busy
//           in_end_*, in_query_*
// result    out_status, out_path_index, out_reverse,  one cycle, marked by out_strobe
//           out_distance_sq
//
// Load beat: the captured entry is written to the table in the load state and the result is registered.
// Query beat: the scan reads the first min(paths_in_use, 1024) table entries, one per cycle,
// from the point memory into a five-stage distance and compare pipeline; the pipeline then
// drains and the result is registered from the nearest pending entry found.
// After reset the pending marks are swept clear with busy high.
// Reset is synchronous, active low. The receiver cannot stall; busy holds off the sender.
`default_nettype none

module nearest_unused_path_selector
  import nups_pkg::*;
(
  input  wire logic                      clk,
  input  wire logic                      rst_n,
  input  wire logic                      cfg_wr_en,
  input  wire logic [CFG_W-1:0]          cfg_wr_data,
  input  wire logic                      start,
  output logic                           busy,
  input  wire logic                      in_opcode,
  input  wire logic [IDX_W-1:0]          in_entry_index,
  input  wire logic signed [COORD_W-1:0] in_start_x,
  input  wire logic signed [COORD_W-1:0] in_start_y,
  input  wire logic signed [COORD_W-1:0] in_end_x,
  input  wire logic signed [COORD_W-1:0] in_end_y,
  input  wire logic signed [COORD_W-1:0] in_query_x,
  input  wire logic signed [COORD_W-1:0] in_query_y,
  output logic                           out_strobe,
  output logic [1:0]                     out_status,
  output logic [IDX_W-1:0]               out_path_index,
  output logic                           out_reverse,
  output logic [DIST_W-1:0]              out_distance_sq
);

  dp_cmd_t    cmd;
  dp_status_t status;

  nups_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .start     (start),
    .in_opcode (in_opcode),
    .status    (status),
    .cmd       (cmd),
    .busy      (busy)
  );

  nups_dpath u_dpath (
    .clk             (clk),
    .rst_n           (rst_n),
    .cmd             (cmd),
    .status          (status),
    .cfg_wr_en       (cfg_wr_en),
    .cfg_wr_data     (cfg_wr_data),
    .in_entry_index  (in_entry_index),
    .in_start_x      (in_start_x),
    .in_start_y      (in_start_y),
    .in_end_x        (in_end_x),
    .in_end_y        (in_end_y),
    .in_query_x      (in_query_x),
    .in_query_y      (in_query_y),
    .out_strobe      (out_strobe),
    .out_status      (out_status),
    .out_path_index  (out_path_index),
    .out_reverse     (out_reverse),
    .out_distance_sq (out_distance_sq)
  );

endmodule

`default_nettype wire
